[hdl/i2ces_pkg.sv]
// ----------------------------------------------------------------------------
// i2ces_pkg
// types and constants shared by the i2c master event sequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package i2ces_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    // busy codes reported on a start command
    localparam logic [1:0] BUSY_READY = 2'd0;
    localparam logic [1:0] BUSY_TX    = 2'd1;
    localparam logic [1:0] BUSY_RX    = 2'd2;

    // status flag bit positions
    localparam int F_SB    = 0;
    localparam int F_ADDR  = 1;
    localparam int F_BTF   = 2;
    localparam int F_STOPF = 3;
    localparam int F_TXE   = 4;
    localparam int F_RXNE  = 5;

    // config register byte addresses
    localparam logic [2:0] ADDR_ACK_ENABLE = 3'd0;

    typedef enum logic [2:0] {
        ST_READY = 3'b001,
        ST_TX    = 3'b010,
        ST_RX    = 3'b100
    } xfer_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] slave_addr;
        logic [7:0] length;
        logic       repeat_start;
        logic [5:0] status_flags;
        logic       master_mode;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] busy_result;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       gen_start;
        logic       gen_stop;
        logic       ack_level;
        logic       tx_done;
        logic       rx_done;
        logic       stop_seen;
    } out_item_t;

endpackage

`default_nettype wire

[hdl/i2ces_regs.sv]
// ----------------------------------------------------------------------------
// i2ces_regs
// apb configuration register file (ack_enable)
// ----------------------------------------------------------------------------
`default_nettype none

module i2ces_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             ack_enable
);
    import i2ces_pkg::*;

    logic ack_enable_reg;
    logic ack_enable_next;
    logic wr_en;
    logic hit;

    // byte offset bits are ignored
    assign hit    = ({paddr[2], 2'b00} == ADDR_ACK_ENABLE);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        ack_enable_next = ack_enable_reg;
        if (wr_en && hit)
        begin
            ack_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_enable_reg <= 1'b1;
        end
        else
        begin
            ack_enable_reg <= ack_enable_next;
        end
    end

    assign prdata     = hit ? {31'd0, ack_enable_reg} : 32'd0;
    assign ack_enable = ack_enable_reg;

endmodule

`default_nettype wire

[hdl/i2ces_engine.sv]
// ----------------------------------------------------------------------------
// i2ces_engine
// transfer state and combinational command / event decision logic
// ----------------------------------------------------------------------------
`default_nettype none

module i2ces_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire i2ces_pkg::in_item_t  item,
    input  wire logic                 ack_enable,
    output i2ces_pkg::out_item_t      result
);
    import i2ces_pkg::*;

    xfer_state_t xfer_state_reg,    xfer_state_next;
    logic [7:0]  tx_remaining_reg,  tx_remaining_next;
    logic [7:0]  rx_remaining_reg,  rx_remaining_next;
    logic [7:0]  rx_total_reg,      rx_total_next;
    logic [6:0]  target_addr_reg,   target_addr_next;
    logic        hold_repeat_reg,   hold_repeat_next;
    logic        event_irq_on_reg,  event_irq_on_next;
    logic        buffer_irq_on_reg, buffer_irq_on_next;
    logic        ack_bit_reg,       ack_bit_next;

    logic [1:0]  busy_code;

    always_comb
    begin
        unique case (xfer_state_reg)
            ST_TX:   busy_code = BUSY_TX;
            ST_RX:   busy_code = BUSY_RX;
            default: busy_code = BUSY_READY;
        endcase
    end

    always_comb
    begin
        logic       ev;
        logic       buf_on;
        logic [5:0] fl;
        logic [7:0] rx_rem_new;

        ev         = event_irq_on_reg;
        buf_on     = buffer_irq_on_reg;
        fl         = item.status_flags;
        rx_rem_new = rx_remaining_reg;

        xfer_state_next    = xfer_state_reg;
        tx_remaining_next  = tx_remaining_reg;
        rx_remaining_next  = rx_remaining_reg;
        rx_total_next      = rx_total_reg;
        target_addr_next   = target_addr_reg;
        hold_repeat_next   = hold_repeat_reg;
        event_irq_on_next  = event_irq_on_reg;
        buffer_irq_on_next = buffer_irq_on_reg;
        ack_bit_next       = ack_bit_reg;
        result             = '0;

        if (fire)
        begin
            case (item.command) inside
                CMD_WRITE, CMD_READ:
                begin
                    result.busy_result = busy_code;
                    if (xfer_state_reg == ST_READY)
                    begin
                        if (item.command == CMD_WRITE)
                        begin
                            tx_remaining_next = item.length;
                            xfer_state_next   = ST_TX;
                        end
                        else
                        begin
                            rx_remaining_next = item.length;
                            rx_total_next     = item.length;
                            xfer_state_next   = ST_RX;
                        end
                        target_addr_next   = item.slave_addr;
                        hold_repeat_next   = item.repeat_start;
                        result.gen_start   = 1'b1;
                        event_irq_on_next  = 1'b1;
                        buffer_irq_on_next = 1'b1;
                    end
                end
                CMD_EVENT:
                begin
                    // start sent: address byte with r/w bit
                    if (ev && fl[F_SB])
                    begin
                        if (xfer_state_reg == ST_TX)
                        begin
                            result.dr_write = 1'b1;
                            result.dr_value = {target_addr_reg, 1'b0};
                        end
                        else if (xfer_state_reg == ST_RX)
                        begin
                            result.dr_write = 1'b1;
                            result.dr_value = {target_addr_reg, 1'b1};
                        end
                    end
                    // single byte read: nack right after address
                    if (ev && fl[F_ADDR] && item.master_mode &&
                        xfer_state_reg == ST_RX && rx_total_reg == 8'd1)
                    begin
                        ack_bit_next = 1'b0;
                    end
                    // send finished
                    if (ev && fl[F_BTF] && fl[F_TXE] &&
                        xfer_state_reg == ST_TX && tx_remaining_reg == 8'd0)
                    begin
                        result.gen_stop    = !hold_repeat_reg;
                        event_irq_on_next  = 1'b0;
                        buffer_irq_on_next = 1'b0;
                        xfer_state_next    = ST_READY;
                        tx_remaining_next  = 8'd0;
                        result.tx_done     = 1'b1;
                    end
                    if (ev && fl[F_STOPF])
                    begin
                        result.stop_seen = 1'b1;
                    end
                    // next data byte; exclusive with send finished
                    if (ev && buf_on && fl[F_TXE] && item.master_mode &&
                        xfer_state_reg == ST_TX && tx_remaining_reg != 8'd0)
                    begin
                        result.dr_write   = 1'b1;
                        result.dr_value   = item.tx_byte;
                        tx_remaining_next = tx_remaining_reg - 8'd1;
                    end
                    if (ev && buf_on && fl[F_RXNE] && item.master_mode &&
                        xfer_state_reg == ST_RX)
                    begin
                        if (rx_total_reg != 8'd0)
                        begin
                            if (rx_total_reg > 8'd1 && rx_remaining_reg == 8'd2)
                            begin
                                ack_bit_next = 1'b0;
                            end
                            result.rx_valid = 1'b1;
                            result.rx_data  = item.rx_byte;
                            rx_rem_new      = rx_remaining_reg - 8'd1;
                        end
                        rx_remaining_next = rx_rem_new;
                        if (rx_rem_new == 8'd0)
                        begin
                            result.gen_stop    = !hold_repeat_reg;
                            event_irq_on_next  = 1'b0;
                            buffer_irq_on_next = 1'b0;
                            xfer_state_next    = ST_READY;
                            rx_remaining_next  = 8'd0;
                            rx_total_next      = 8'd0;
                            if (ack_enable)
                            begin
                                ack_bit_next = 1'b1;
                            end
                            result.rx_done = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.ack_level = ack_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_state_reg    <= ST_READY;
            tx_remaining_reg  <= 8'd0;
            rx_remaining_reg  <= 8'd0;
            rx_total_reg      <= 8'd0;
            target_addr_reg   <= 7'd0;
            hold_repeat_reg   <= 1'b0;
            event_irq_on_reg  <= 1'b0;
            buffer_irq_on_reg <= 1'b0;
            ack_bit_reg       <= 1'b1;
        end
        else
        begin
            xfer_state_reg    <= xfer_state_next;
            tx_remaining_reg  <= tx_remaining_next;
            rx_remaining_reg  <= rx_remaining_next;
            rx_total_reg      <= rx_total_next;
            target_addr_reg   <= target_addr_next;
            hold_repeat_reg   <= hold_repeat_next;
            event_irq_on_reg  <= event_irq_on_next;
            buffer_irq_on_reg <= buffer_irq_on_next;
            ack_bit_reg       <= ack_bit_next;
        end
    end

endmodule

`default_nettype wire

[hdl/i2c_master_event_sequencer_core.sv]
// ----------------------------------------------------------------------------
// i2c_master_event_sequencer_core
// interrupt-driven i2c master transfer sequencer, one result per request
// ----------------------------------------------------------------------------
// usage
//   in channel : in_valid / in_stall / in_item, one request per accept
//                (start write, start read, or bus event with status flags)
//   out channel: out_valid / out_stall / out_item, exactly one result for
//                each request, in request order
//   apb port   : one register, ack_enable at byte address 0
// pipeline
//   an accepted request waits in the input register and is decided into
//   the output register when it advances (output register empty or
//   draining); its result is then offered on the out channel
// throughput
//   one request per cycle while out_stall is low; the rate is set by the
//   single decision pass of the engine between the input and output registers
// reset
//   clears both pipeline valids, returns the transfer state to ready with
//   interrupts off and ack set, and sets ack_enable
// stall
//   a stalled result holds in the output register; the input register
//   keeps taking one more request, then in_stall rises until the output
//   register drains
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_event_sequencer_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire i2ces_pkg::in_item_t  in_item,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output i2ces_pkg::out_item_t      out_item,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);
    import i2ces_pkg::*;

    // input register stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;

    // output register stage
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      advance;
    logic      in_take;
    logic      ack_enable;
    out_item_t result;

    // request moves into the output register when it is empty or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    i2ces_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .ack_enable (ack_enable)
    );

    // state updates only when the request actually advances
    i2ces_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (in_item_reg),
        .ack_enable (ack_enable),
        .result     (result)
    );

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

[hdl/i2ces_checker.sv]
// ----------------------------------------------------------------------------
// i2ces_checker
// port-level checks on the result channel of the sequencer core
// ----------------------------------------------------------------------------
`default_nettype none

module i2ces_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire i2ces_pkg::out_item_t  out_item
);
    import i2ces_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // no data register value without a write
    a_dr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.dr_write |-> out_item.dr_value == 8'd0)
        else $error("dr_value set without dr_write");

    // no received byte without delivery
    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.rx_valid |-> out_item.rx_data == 8'd0)
        else $error("rx_data set without rx_valid");

    // a granted start comes only from ready and does nothing else
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.gen_start |->
            out_item.busy_result == BUSY_READY && !out_item.dr_write &&
            !out_item.tx_done && !out_item.rx_done && !out_item.gen_stop)
        else $error("start request mixed with event activity");

    // busy code never takes the unused value
    a_busy_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.busy_result != 2'd3)
        else $error("busy_result out of range");

endmodule

bind i2c_master_event_sequencer_core i2ces_checker u_i2ces_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
